FILE: hw/rtl/dam_pkg.sv
// Package with the shared constants, codes and the result beat layout of the alarm monitor.
package dam_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LEVEL_W  = 16;
    localparam int unsigned DOOR_W   = 2;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned DBMIN_W  = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [TIME_W-1:0] POWER_DEBOUNCE_S        = 32'd5;
    localparam logic [TIME_W-1:0] POWER_REPORT_INTERVAL_S = 32'd60;
    localparam logic [TIME_W-1:0] SMOKE_AUDIO_INTERVAL_S  = 32'd30;

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'd2;

    typedef enum logic [1:0] {
        PWR_REP_NONE  = 2'd0,
        PWR_REP_LOST  = 2'd1,
        PWR_REP_RECOV = 2'd2
    } pwr_rep_t;

    typedef enum logic [1:0] {
        LOCK_NONE  = 2'd0,
        LOCK_OPEN  = 2'd1,
        LOCK_CLOSE = 2'd2
    } lock_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOKE_MODE      = 3'd0,
        REG_SMOKE_DEBOUNCE  = 3'd1,
        REG_SMOKE_THRESHOLD = 3'd2,
        REG_SMOKE_INTERVAL  = 3'd3,
        REG_DOOR_MODE       = 3'd4,
        REG_DOOR_DEBOUNCE   = 3'd5,
        REG_DOOR_TRIGGER    = 3'd6,
        REG_DOOR_INTERVAL   = 3'd7
    } cfg_reg_t;

    // Result beat, lowest field last (packed structs fill from the top down).
    typedef struct packed {
        logic [1:0]         pad;
        logic [DOOR_W-1:0]  door_state_out;
        logic               door_report;
        logic               play_smoke_audio;
        lock_cmd_t          door_lock_cmd;
        logic [LEVEL_W-1:0] smoke_level_out;
        logic               smoke_report;
        logic               restore_outputs;
        pwr_rep_t           power_report;
        logic               emergency_light_on;
        logic [2:0]         alarm_bits;
    } result_t;

endpackage

FILE: hw/rtl/debounced_alarm_monitor.sv
// Debounced three-channel alarm monitor (power, smoke, door) with a two-entry result buffer.
//
// Every input beat is one check tick carrying a seconds timestamp, the mains-off flag, the
// smoke level and the door status, and it yields exactly one result beat. The channel logic
// is a single pass of 32-bit subtract-and-compare per channel between the input port and the
// result register, so the block takes one beat per clock cycle while s_tready is high, and each
// result is written to the main stage, or to the skid stage while the main stage is held. Two
// result registers (a main stage and a skid stage) let the input side keep accepting a
// beat while a finished result still waits for the downstream side; s_tready drops only when
// both are full. Configuration writes on the cfg channel are always accepted and must be issued
// only while the block is idle. Reset relieves all three channels and clears their time marks.
module debounced_alarm_monitor
    import dam_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Input beat: now_s[31:0], mains_off[32], smoke_level[48:33], door_state[50:49], zeros.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // Result beat: alarm_bits[2:0], emergency_light_on[3], power_report[5:4],
    // restore_outputs[6], smoke_report[7], smoke_level_out[23:8], door_lock_cmd[25:24],
    // play_smoke_audio[26], door_report[27], door_state_out[29:28], zeros.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [MODE_W-1:0]  smoke_mode_reg;
    logic [LEVEL_W-1:0] smoke_debounce_reg;
    logic [LEVEL_W-1:0] smoke_threshold_reg;
    logic [LEVEL_W-1:0] smoke_interval_reg;
    logic [MODE_W-1:0]  door_mode_reg;
    logic [DBMIN_W-1:0] door_debounce_reg;
    logic [DOOR_W-1:0]  door_trigger_reg;
    logic [LEVEL_W-1:0] door_interval_reg;

    // Channel state.
    logic [2:0]        active_reg, active_next;
    logic [TIME_W-1:0] mark0_reg, mark0_next;
    logic [TIME_W-1:0] mark1_reg, mark1_next;
    logic [TIME_W-1:0] mark2_reg, mark2_next;
    logic [TIME_W-1:0] audio_mark_reg, audio_mark_next;

    // Result buffer.
    result_t out_reg, skid_reg, res_next;
    logic    out_valid_reg, skid_valid_reg;

    logic              in_fire, out_fire;
    logic [TIME_W-1:0] now;
    logic              mains_off;
    logic [LEVEL_W-1:0] level;
    logic [DOOR_W-1:0]  door;
    logic [TIME_W-1:0]  d0, d1, d2, da;
    logic [13:0]        door_debounce_s;

    assign now       = s_tdata[31:0];
    assign mains_off = s_tdata[32];
    assign level     = s_tdata[48:33];
    assign door      = s_tdata[50:49];

    assign cfg_ready = 1'b1;
    assign s_tready  = ~skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign in_fire   = s_tvalid & s_tready;
    assign out_fire  = out_valid_reg & m_tready;

    // Elapsed times since each mark, modulo 2^32.
    assign d0 = now - mark0_reg;
    assign d1 = now - mark1_reg;
    assign d2 = now - mark2_reg;
    assign da = now - audio_mark_reg;

    // Minutes to seconds: x * 60 = x * 64 - x * 4.
    assign door_debounce_s = {door_debounce_reg, 6'd0} - {4'd0, door_debounce_reg, 2'd0};

    always_comb begin
        active_next     = active_reg;
        mark0_next      = mark0_reg;
        mark1_next      = mark1_reg;
        mark2_next      = mark2_reg;
        audio_mark_next = audio_mark_reg;
        res_next        = '0;

        // Power channel, always enabled.
        if (mains_off) begin
            if (!active_reg[0]) begin
                if (d0 >= POWER_DEBOUNCE_S) begin
                    mark0_next                  = now;
                    active_next[0]              = 1'b1;
                    res_next.emergency_light_on = 1'b1;
                    res_next.power_report       = PWR_REP_LOST;
                end
            end else begin
                res_next.emergency_light_on = 1'b1;
                if (d0 >= POWER_REPORT_INTERVAL_S) begin
                    mark0_next            = now;
                    res_next.power_report = PWR_REP_LOST;
                end
            end
        end else begin
            if (active_reg[0]) begin
                active_next[0]           = 1'b0;
                res_next.restore_outputs = 1'b1;
                res_next.power_report    = PWR_REP_RECOV;
            end
            mark0_next = now;
        end

        // Smoke channel; mode off leaves its state untouched.
        if (smoke_mode_reg != MODE_OFF) begin
            if (level >= smoke_threshold_reg) begin
                if (!active_reg[1]) begin
                    if (d1 >= {16'd0, smoke_debounce_reg}) begin
                        mark1_next                = now;
                        active_next[1]            = 1'b1;
                        res_next.door_lock_cmd    = LOCK_OPEN;
                        res_next.play_smoke_audio = 1'b1;
                        audio_mark_next           = now;
                        res_next.smoke_report     = 1'b1;
                    end
                end else begin
                    if (da > SMOKE_AUDIO_INTERVAL_S) begin
                        res_next.door_lock_cmd    = LOCK_OPEN;
                        res_next.play_smoke_audio = 1'b1;
                        audio_mark_next           = now;
                    end
                    if (smoke_mode_reg == MODE_PERIODIC && smoke_interval_reg != '0 &&
                        d1 >= {16'd0, smoke_interval_reg}) begin
                        mark1_next            = now;
                        res_next.smoke_report = 1'b1;
                    end
                end
            end else begin
                if (active_reg[1]) begin
                    active_next[1]         = 1'b0;
                    res_next.door_lock_cmd = LOCK_CLOSE;
                    res_next.smoke_report  = 1'b1;
                end
                mark1_next = now;
            end
        end

        // Door channel; mode off leaves its state untouched.
        if (door_mode_reg != MODE_OFF) begin
            if (door == door_trigger_reg) begin
                if (!active_reg[2]) begin
                    if (d2 >= {18'd0, door_debounce_s}) begin
                        mark2_next           = now;
                        active_next[2]       = 1'b1;
                        res_next.door_report = 1'b1;
                    end
                end else if (door_mode_reg == MODE_PERIODIC && door_interval_reg != '0 &&
                             d2 >= {16'd0, door_interval_reg}) begin
                    mark2_next           = now;
                    res_next.door_report = 1'b1;
                end
            end else begin
                if (active_reg[2]) begin
                    active_next[2]       = 1'b0;
                    res_next.door_report = 1'b1;
                end
                mark2_next = now;
            end
        end

        res_next.alarm_bits      = active_next;
        res_next.smoke_level_out = res_next.smoke_report ? level : '0;
        res_next.door_state_out  = res_next.door_report ? door : '0;
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smoke_mode_reg      <= '0;
            smoke_debounce_reg  <= '0;
            smoke_threshold_reg <= '0;
            smoke_interval_reg  <= '0;
            door_mode_reg       <= '0;
            door_debounce_reg   <= '0;
            door_trigger_reg    <= '0;
            door_interval_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_SMOKE_MODE:      smoke_mode_reg      <= cfg_data[MODE_W-1:0];
                REG_SMOKE_DEBOUNCE:  smoke_debounce_reg  <= cfg_data;
                REG_SMOKE_THRESHOLD: smoke_threshold_reg <= cfg_data;
                REG_SMOKE_INTERVAL:  smoke_interval_reg  <= cfg_data;
                REG_DOOR_MODE:       door_mode_reg       <= cfg_data[MODE_W-1:0];
                REG_DOOR_DEBOUNCE:   door_debounce_reg   <= cfg_data[DBMIN_W-1:0];
                REG_DOOR_TRIGGER:    door_trigger_reg    <= cfg_data[DOOR_W-1:0];
                REG_DOOR_INTERVAL:   door_interval_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state advances on every accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            mark0_reg      <= '0;
            mark1_reg      <= '0;
            mark2_reg      <= '0;
            audio_mark_reg <= '0;
        end else if (in_fire) begin
            active_reg     <= active_next;
            mark0_reg      <= mark0_next;
            mark1_reg      <= mark1_next;
            mark2_reg      <= mark2_next;
            audio_mark_reg <= audio_mark_next;
        end
    end

    // Result buffer: the skid stage only fills while the main stage is held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_fire) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_fire;
                    if (in_fire) begin
                        out_reg <= res_next;
                    end
                end
            end else if (in_fire) begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule
